### sv/laser_range_conditioning_core_macros.svh
// Assertion macros shared by the laser range conditioning RTL.
`ifndef LASER_RANGE_CONDITIONING_CORE_MACROS_SVH
`define LASER_RANGE_CONDITIONING_CORE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define LRC_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define LRC_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### sv/lrc_pkg.sv
// Package with widths, register indices and shared types of the range conditioner.
package lrc_pkg;

    localparam int RANGE_BITS    = 20;
    localparam int MINR_BITS     = 20;
    localparam int INV_BITS      = 20;
    localparam int COS_BITS      = 17;
    localparam int SLOPE_BITS    = 24;
    localparam int ALPHA_BITS    = 32;
    localparam int BETA_BITS     = 24;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // Q1.16 cosine scale
    localparam int COS_FRAC = 16;

    // Squared range and positive denominator widths
    localparam int SQ_BITS  = 2 * RANGE_BITS;
    localparam int DEN_BITS = SQ_BITS + 1;

    // Corrected sum before saturation
    localparam int SUM_BITS = ((RANGE_BITS > ALPHA_BITS) ? RANGE_BITS : ALPHA_BITS) + 1;

    // Width for comparisons against the minimum range
    localparam int CMP_BITS = (RANGE_BITS > MINR_BITS) ? RANGE_BITS : MINR_BITS;

    // Shadow test widths
    localparam int COSP_BITS  = RANGE_BITS + COS_BITS;
    localparam int THR_BITS   = RANGE_BITS + SLOPE_BITS;
    localparam int SHIFT_BITS = RANGE_BITS + COS_FRAC;
    localparam int TST_A      = (COSP_BITS > THR_BITS) ? COSP_BITS : THR_BITS;
    localparam int TST_BITS   = (TST_A > SHIFT_BITS) ? TST_A : SHIFT_BITS;

    // Divider: quotient bits retired per cycle
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = ALPHA_BITS / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_BITS      = $clog2(DIV_STEPS);

    localparam logic [RANGE_BITS-1:0] RANGE_SAT = '1;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indices
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVALID_VALUE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COS_INCREMENT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHADOW_SLOPE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIST_ALPHA    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIST_BETA     = 3'd5;

    typedef struct packed {
        logic [MINR_BITS-1:0]         range_floor;
        logic [INV_BITS-1:0]          invalid_value;
        logic [COS_BITS-1:0]          cos_increment;
        logic [SLOPE_BITS-1:0]        shadow_slope;
        logic [ALPHA_BITS-1:0]        dist_alpha;
        logic signed [BETA_BITS-1:0]  dist_beta;
    } lrc_cfg_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [RANGE_BITS-1:0] range;
        logic                  last;
        logic                  do_div;
        logic [DEN_BITS-1:0]   denom;
    } lrc_entry_t;

endpackage

### sv/lrc_front.sv
// Front part: accepts samples, squares the range and classifies the correction.
module lrc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lrc_pkg::lrc_cfg_t          cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [lrc_pkg::RANGE_BITS-1:0] range_sample,
    input  logic                       scan_end,
    output logic                       q_push,
    output lrc_pkg::lrc_entry_t        q_entry,
    input  logic                       q_full
);
    import lrc_pkg::*;

    logic                  stg_valid_reg;
    logic                  stg_valid_next;
    logic [RANGE_BITS-1:0] stg_range_reg;
    logic                  stg_last_reg;
    logic                  in_take;
    logic [SQ_BITS-1:0]    sq;
    logic signed [DEN_BITS:0] den_s;
    logic                  above_min;

    // Take a new transaction when the stage is empty or drains this cycle
    assign q_push   = stg_valid_reg && !q_full;
    assign in_ready = !stg_valid_reg || !q_full;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (in_take)
        begin
            stg_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // Hold the accepted sample
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stg_range_reg <= range_sample;
            stg_last_reg  <= scan_end;
        end
    end

    // Square the range and add beta to form the denominator
    assign sq        = SQ_BITS'(stg_range_reg) * SQ_BITS'(stg_range_reg);
    assign den_s     = $signed({1'b0, 1'b0, sq}) + (DEN_BITS + 1)'(cfg.dist_beta);
    assign above_min = CMP_BITS'(stg_range_reg) > CMP_BITS'(cfg.range_floor);

    // Correct only above the minimum range and for a positive denominator
    always_comb
    begin
        q_entry.range  = stg_range_reg;
        q_entry.last   = stg_last_reg;
        q_entry.do_div = above_min && !den_s[DEN_BITS] && (den_s != '0);
        q_entry.denom  = den_s[DEN_BITS-1:0];
    end

endmodule

### sv/lrc_queue.sv
// Two-entry queue that decouples the front and back parts.
module lrc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lrc_pkg::lrc_entry_t wr_entry,
    input  logic                pop,
    output lrc_pkg::lrc_entry_t rd_entry,
    output logic                full,
    output logic                empty
);
    import lrc_pkg::*;

    lrc_entry_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic [QCNT_BITS-1:0] cnt_next;

    assign full     = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

### sv/lrc_div.sv
// Iterative restoring divider for the distortion quotient, two bits per cycle.
module lrc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lrc_pkg::ALPHA_BITS-1:0] dividend,
    input  logic [lrc_pkg::DEN_BITS-1:0]   divisor,
    output logic                           done,
    output logic [lrc_pkg::ALPHA_BITS-1:0] quotient
);
    import lrc_pkg::*;

    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_CNT_BITS-1:0] cnt_next;
    logic [DEN_BITS-1:0]     rem_reg;
    logic [DEN_BITS-1:0]     rem_next;
    logic [ALPHA_BITS-1:0]   quo_reg;
    logic [ALPHA_BITS-1:0]   quo_next;
    logic [DEN_BITS-1:0]     dsr_reg;
    logic [DEN_BITS-1:0]     step_rem;
    logic [ALPHA_BITS-1:0]   step_quo;
    logic [DEN_BITS:0]       trial;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Shift in dividend bits and subtract the divisor where it fits
    always_comb
    begin
        step_rem = rem_reg;
        step_quo = quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++)
        begin
            trial    = {step_rem, step_quo[ALPHA_BITS-1]};
            step_quo = {step_quo[ALPHA_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                step_rem    = DEN_BITS'(trial - {1'b0, dsr_reg});
                step_quo[0] = 1'b1;
            end
            else
            begin
                step_rem = trial[DEN_BITS-1:0];
            end
        end
    end

    // Sequence the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            quo_next = step_quo;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

endmodule

### sv/lrc_back.sv
// Back part: corrects the range, runs the shadow test and emits results.
module lrc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lrc_pkg::lrc_cfg_t              cfg,
    input  lrc_pkg::lrc_entry_t            q_entry,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           div_start,
    input  logic                           div_done,
    input  logic [lrc_pkg::ALPHA_BITS-1:0] div_quot,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lrc_pkg::RANGE_BITS-1:0] range_out,
    output logic                           rejected,
    output logic                           scan_last
);
    import lrc_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIV       = 3'd1;
    localparam logic [2:0] ST_CORR      = 3'd2;
    localparam logic [2:0] ST_MUL       = 3'd3;
    localparam logic [2:0] ST_TEST      = 3'd4;
    localparam logic [2:0] ST_EMIT_HELD = 3'd5;
    localparam logic [2:0] ST_EMIT_LAST = 3'd6;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic                  held_valid_reg;
    logic                  held_valid_next;
    logic                  held_pair_reg;
    logic                  held_pair_next;
    logic [RANGE_BITS-1:0] held_range_reg;
    logic [RANGE_BITS-1:0] held_range_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [RANGE_BITS-1:0] r_reg;
    logic [RANGE_BITS-1:0] r_next;
    logic                  last_reg;
    logic                  last_next;
    logic [ALPHA_BITS-1:0] q_reg;
    logic [ALPHA_BITS-1:0] q_next;
    logic [RANGE_BITS-1:0] c_reg;
    logic [RANGE_BITS-1:0] c_next;
    logic [COSP_BITS-1:0]  a_reg;
    logic [COSP_BITS-1:0]  a_next;
    logic [THR_BITS-1:0]   thr_reg;
    logic [THR_BITS-1:0]   thr_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [RANGE_BITS-1:0] out_range_reg;
    logic [RANGE_BITS-1:0] out_range_next;
    logic                  out_rej_reg;
    logic                  out_rej_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  out_free;
    logic [SUM_BITS-1:0]   sum;
    logic [TST_BITS-1:0]   b_val;
    logic [TST_BITS-1:0]   a_val;
    logic [TST_BITS-1:0]   y_val;
    logic                  held_rej;
    logic                  last_rej;

    assign out_valid = out_valid_reg;
    assign range_out = out_range_reg;
    assign rejected  = out_rej_reg;
    assign scan_last = out_last_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Saturating corrected sum
    assign sum = SUM_BITS'(r_reg) + SUM_BITS'(q_reg);

    // Distance of the current sample from the projected held sample
    assign b_val = TST_BITS'(c_reg) << COS_FRAC;
    assign a_val = TST_BITS'(a_reg);
    assign y_val = (b_val > a_val) ? (b_val - a_val) : (a_val - b_val);

    assign held_rej = held_pair_reg || hit_reg
                      || (CMP_BITS'(held_range_reg) < CMP_BITS'(cfg.range_floor));
    assign last_rej = hit_reg || (CMP_BITS'(c_reg) < CMP_BITS'(cfg.range_floor));

    always_comb
    begin
        state_next      = state_reg;
        held_valid_next = held_valid_reg;
        held_pair_next  = held_pair_reg;
        held_range_next = held_range_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        r_next          = r_reg;
        last_next       = last_reg;
        q_next          = q_reg;
        c_next          = c_reg;
        a_next          = a_reg;
        thr_next        = thr_reg;
        hit_next        = hit_reg;
        out_range_next  = out_range_reg;
        out_rej_next    = out_rej_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            // Pop a classified sample and start the divider if needed
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    r_next    = q_entry.range;
                    last_next = q_entry.last;
                    q_next    = '0;
                    if (q_entry.do_div)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_CORR;
                    end
                end
            end
            // Wait for the quotient
            ST_DIV:
            begin
                if (div_done)
                begin
                    q_next     = div_quot;
                    state_next = ST_CORR;
                end
            end
            // Add and saturate
            ST_CORR:
            begin
                c_next     = (sum > SUM_BITS'(RANGE_SAT)) ? RANGE_SAT : sum[RANGE_BITS-1:0];
                state_next = ST_MUL;
            end
            // Project the held sample and scale the threshold
            ST_MUL:
            begin
                a_next     = COSP_BITS'(held_range_reg) * COSP_BITS'(cfg.cos_increment);
                thr_next   = THR_BITS'(held_range_reg) * THR_BITS'(cfg.shadow_slope);
                state_next = ST_TEST;
            end
            // Compare against the threshold
            ST_TEST:
            begin
                hit_next   = held_valid_reg && (y_val > TST_BITS'(thr_reg));
                state_next = ST_EMIT_HELD;
            end
            // Emit the held sample, then hold the current one or flush it
            ST_EMIT_HELD:
            begin
                if (!held_valid_reg || out_free)
                begin
                    if (held_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_range_next = held_rej ? RANGE_BITS'(cfg.invalid_value)
                                                  : held_range_reg;
                        out_rej_next   = held_rej;
                        out_last_next  = 1'b0;
                    end
                    if (last_reg)
                    begin
                        state_next = ST_EMIT_LAST;
                    end
                    else
                    begin
                        held_range_next = c_reg;
                        held_pair_next  = hit_reg;
                        held_valid_next = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            // Emit the final sample of the scan and drop the held state
            ST_EMIT_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_range_next  = last_rej ? RANGE_BITS'(cfg.invalid_value) : c_reg;
                    out_rej_next    = last_rej;
                    out_last_next   = 1'b1;
                    held_range_next = '0;
                    held_pair_next  = 1'b0;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_valid_reg <= 1'b0;
            held_pair_reg  <= 1'b0;
            held_range_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            held_pair_reg  <= held_pair_next;
            held_range_reg <= held_range_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        last_reg      <= last_next;
        q_reg         <= q_next;
        c_reg         <= c_next;
        a_reg         <= a_next;
        thr_reg       <= thr_next;
        hit_reg       <= hit_next;
        out_range_reg <= out_range_next;
        out_rej_reg   <= out_rej_next;
        out_last_reg  <= out_last_next;
    end

endmodule

### sv/laser_range_conditioning_core.sv
// Usage: top level of the laser range conditioner with its configuration registers.
//
// Input channel in_valid/in_ready carries range_sample (Q8.12 m) and scan_end.
// Output channel out_valid/out_ready carries range_out, rejected and scan_last.
// Each sample comes out one transaction late, once its right neighbour is known;
// the transaction marked scan_end also flushes itself right after the held one.
// A sample above the minimum range with a positive denominator passes through the
// two-bit-per-cycle divider (16 iterations) while the back part waits on it. The back
// part handles one input transaction at a time: pop in ST_IDLE, the divider wait in
// ST_DIV when a correction applies, then ST_CORR, ST_MUL, ST_TEST and ST_EMIT_HELD,
// and ST_EMIT_LAST for a scan_end transaction. The back part sets the throughput.
// Receiver stalls hold the back part in its emit states.
// A one-entry input stage and a two-entry queue let the front keep accepting
// while the back waits on a stalled receiver; the output register holds its
// result until out_ready is seen.
// Reset clears the held sample, the queue and the output register, and loads
// the register defaults. cfg_write with cfg_index and cfg_data writes a
// register at once; write only while the block is idle. Unknown indices are dropped.
module laser_range_conditioning_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lrc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lrc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lrc_pkg::RANGE_BITS-1:0]    range_sample,
    input  logic                              scan_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lrc_pkg::RANGE_BITS-1:0]    range_out,
    output logic                              rejected,
    output logic                              scan_last
);
    import lrc_pkg::*;

`include "laser_range_conditioning_core_macros.svh"

    lrc_cfg_t              cfg_reg;
    lrc_cfg_t              cfg_next;
    lrc_entry_t            push_entry;
    lrc_entry_t            head_entry;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic                  div_start;
    logic                  div_done;
    logic [ALPHA_BITS-1:0] div_quot;
    logic                  rej_value_ok;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RANGE_FLOOR:   cfg_next.range_floor   = cfg_data[MINR_BITS-1:0];
                REG_INVALID_VALUE: cfg_next.invalid_value = cfg_data[INV_BITS-1:0];
                REG_COS_INCREMENT: cfg_next.cos_increment = cfg_data[COS_BITS-1:0];
                REG_SHADOW_SLOPE:  cfg_next.shadow_slope  = cfg_data[SLOPE_BITS-1:0];
                REG_DIST_ALPHA:    cfg_next.dist_alpha    = cfg_data[ALPHA_BITS-1:0];
                REG_DIST_BETA:     cfg_next.dist_beta     = $signed(cfg_data[BETA_BITS-1:0]);
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_floor   <= '0;
            cfg_reg.invalid_value <= INV_BITS'(1048575);
            cfg_reg.cos_increment <= COS_BITS'(65536);
            cfg_reg.shadow_slope  <= '0;
            cfg_reg.dist_alpha    <= '0;
            cfg_reg.dist_beta     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept and classify
    lrc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .range_sample (range_sample),
        .scan_end     (scan_end),
        .q_push       (q_push),
        .q_entry      (push_entry),
        .q_full       (q_full)
    );

    // Decouple front and back
    lrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (push_entry),
        .pop      (q_pop),
        .rd_entry (head_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Divide alpha by the denominator
    lrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg_reg.dist_alpha),
        .divisor  (head_entry.denom),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Correct, test and emit
    lrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_entry   (head_entry),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .div_start (div_start),
        .div_done  (div_done),
        .div_quot  (div_quot),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .range_out (range_out),
        .rejected  (rejected),
        .scan_last (scan_last)
    );

    // A rejected result carries the invalid value
    assign rej_value_ok = (range_out == cfg_reg.invalid_value);

    `LRC_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "queue popped while empty")
    `LRC_ASSERT_NOW(a_push_notfull, q_push, !q_full, "queue pushed while full")
    `LRC_ASSERT_NOW(a_rej_value, out_valid && rejected, rej_value_ok, "wrong rejected value")
    `LRC_ASSERT_NEXT(a_pop_spacing, q_pop, !q_pop, "back popped in consecutive cycles")

endmodule

### tb/tb_laser_range_conditioning_core.sv
// Self-checking testbench for the laser range conditioner: directed and random scans.
module tb_laser_range_conditioning_core;

    import lrc_pkg::*;

    typedef logic [RANGE_BITS-1:0] range_t;

    typedef struct packed {
        range_t meas;
        logic   eos;
    } sample_t;

    typedef struct packed {
        range_t level;
        logic   rej;
        logic   last;
    } result_t;

    // Indices past the register list; writes to them must be dropped
    localparam logic [CFG_IDX_BITS-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] SPARE_INDEX_B = 3'd7;

    localparam int SETTLE_CYCLES = 100;
    localparam int RUN_LIMIT     = 20000000;

    localparam logic [31:0] RANGE_TOP = 32'h000F_FFFF;
    localparam logic [31:0] SLOPE_TOP = 32'h00FF_FFFF;
    localparam logic [31:0] COS_UNITY = 32'h0001_0000;
    localparam logic [31:0] COS_TOP   = 32'h0001_FFFF;
    localparam logic [31:0] BETA_MOST = 32'h007F_FFFF;
    localparam logic [31:0] BETA_LEAST = 32'h0080_0000;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     cfg_write    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data     = '0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    range_t                   range_sample = '0;
    logic                     scan_end     = 1'b0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    range_t                   range_out;
    logic                     rejected;
    logic                     scan_last;

    // Register mirror, as the block sees it
    logic [MINR_BITS-1:0]        cfg_min   = '0;
    logic [INV_BITS-1:0]         cfg_inv   = '1;
    logic [COS_BITS-1:0]         cfg_cos   = COS_BITS'(COS_UNITY);
    logic [SLOPE_BITS-1:0]       cfg_slope = '0;
    logic [ALPHA_BITS-1:0]       cfg_alpha = '0;
    logic signed [BETA_BITS-1:0] cfg_beta  = '0;

    // Sample waiting for its right-hand neighbour
    range_t held_level  = '0;
    logic   held_broken = 1'b0;
    logic   held_present = 1'b0;

    sample_t pending_samples[$];
    result_t expected_samples[$];

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    logic        in_taken        = 1'b0;
    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          samples_sent    = 0;
    int          settings_loaded = 0;

    laser_range_conditioning_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .range_sample (range_sample),
        .scan_end     (scan_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .range_out    (range_out),
        .rejected     (rejected),
        .scan_last    (scan_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Add alpha / (beta + r^2) above the minimum range, saturating the sum
    function automatic range_t correct_for_distortion(range_t r);
        logic [63:0] r_sq;
        logic [63:0] den;
        logic [63:0] beta_mag;
        logic [63:0] total;
        longint      beta_wide;
        if (r <= cfg_min)
            return r;
        r_sq      = 64'(r) * 64'(r);
        beta_wide = longint'(cfg_beta);
        if (beta_wide < 0)
        begin
            beta_mag = -beta_wide;
            if (r_sq <= beta_mag)
                return r;
            den = r_sq - beta_mag;
        end
        else
        begin
            den = r_sq + beta_wide;
            if (den == 0)
                return r;
        end
        total = 64'(r) + 64'(cfg_alpha) / den;
        if (total > 64'(RANGE_SAT))
            return RANGE_SAT;
        return range_t'(total);
    endfunction

    // Shadow or veiling edge between neighbours: |c - p*cos| > p*slope in Q.16
    function automatic logic edge_breaks_pair(range_t prev, range_t cur);
        logic [63:0] along;
        logic [63:0] scaled;
        logic [63:0] gap;
        logic [63:0] limit;
        along  = 64'(prev) * 64'(cfg_cos);
        scaled = 64'(cur) << COS_FRAC;
        gap    = (scaled > along) ? scaled - along : along - scaled;
        limit  = 64'(prev) * 64'(cfg_slope);
        return gap > limit;
    endfunction

    task automatic expect_result(range_t level, logic rej, logic last);
        result_t res;
        res.level = rej ? range_t'(cfg_inv) : level;
        res.rej   = rej;
        res.last  = last;
        expected_samples = {expected_samples, res};
    endtask

    // Advance the predictor by one accepted sample
    task automatic condition_sample(range_t raw, logic eos);
        range_t cur;
        logic   hit;
        cur = correct_for_distortion(raw);
        hit = 1'b0;
        if (held_present)
        begin
            hit = edge_breaks_pair(held_level, cur);
            expect_result(held_level, held_broken || hit || (held_level < cfg_min), 1'b0);
        end
        if (eos)
        begin
            expect_result(cur, hit || (cur < cfg_min), 1'b1);
            held_level   = '0;
            held_broken  = 1'b0;
            held_present = 1'b0;
        end
        else
        begin
            held_level   = cur;
            held_broken  = hit;
            held_present = 1'b1;
        end
    endtask

    task automatic apply_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        unique case (idx)
            REG_RANGE_FLOOR:   cfg_min   = data[MINR_BITS-1:0];
            REG_INVALID_VALUE: cfg_inv   = data[INV_BITS-1:0];
            REG_COS_INCREMENT: cfg_cos   = data[COS_BITS-1:0];
            REG_SHADOW_SLOPE:  cfg_slope = data[SLOPE_BITS-1:0];
            REG_DIST_ALPHA:    cfg_alpha = data[ALPHA_BITS-1:0];
            REG_DIST_BETA:     cfg_beta  = data[BETA_BITS-1:0];
            default:           ;
        endcase
    endtask

    // Sample both channels and the register port; predict and check
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            cfg_min      = '0;
            cfg_inv      = '1;
            cfg_cos      = COS_BITS'(COS_UNITY);
            cfg_slope    = '0;
            cfg_alpha    = '0;
            cfg_beta     = '0;
            held_level   = '0;
            held_broken  = 1'b0;
            held_present = 1'b0;
            in_taken     = 1'b0;
        end
        else
        begin
            if (cfg_write)
                apply_register(cfg_index, cfg_data);
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                condition_sample(range_sample, scan_end);
                samples_sent++;
            end
            if (out_valid && out_ready)
            begin
                got.level = range_out;
                got.rej   = rejected;
                got.last  = scan_last;
                if (expected_samples.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result range_out %h rejected %b scan_last %b",
                             $time, got.level, got.rej, got.last);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    results_checked++;
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: expected range_out %h rejected %b scan_last %b",
                                 $time, want.level, want.rej, want.last);
                        $display("%0t:   actual range_out %h rejected %b scan_last %b",
                                 $time, got.level, got.rej, got.last);
                    end
                end
            end
        end
    end

    // Present queued samples; hold each transaction until it is accepted
    always @(negedge clk)
    begin : driver
        sample_t queued;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                queued = pending_samples.pop_front();
                in_valid     <= 1'b1;
                range_sample <= queued.meas;
                scan_end     <= queued.eos;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the receiver at random
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_pacing(int unsigned sender_pct, int unsigned recv_pct);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
    endtask

    task automatic send(range_t r, logic eos);
        sample_t s;
        s.meas = r;
        s.eos  = eos;
        pending_samples = {pending_samples, s};
    endtask

    // Hold off until every transaction is in and every result is out
    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Start value for a scan: small, near the minimum, mid, far, or near saturation
    function automatic range_t fresh_range();
        int unsigned pick;
        int          lo;
        int          hi;
        pick = $urandom_range(99);
        if (pick < 25)
            return range_t'($urandom_range(4095));
        if (pick < 50)
        begin
            lo = (int'(cfg_min) > 64) ? int'(cfg_min) - 64 : 0;
            hi = (int'(cfg_min) < int'(RANGE_TOP) - 64) ? int'(cfg_min) + 64 : int'(RANGE_TOP);
            return range_t'($urandom_range(hi, lo));
        end
        if (pick < 75)
            return range_t'($urandom_range(262143, 4096));
        if (pick < 90)
            return range_t'($urandom_range(RANGE_TOP, 262144));
        return RANGE_SAT - range_t'($urandom_range(63));
    endfunction

    // Neighbour: mostly a small step, sometimes an edge, sometimes noise
    function automatic range_t next_range(range_t prev);
        int unsigned pick;
        int          v;
        pick = $urandom_range(99);
        if (pick < 5)
            return range_t'($urandom());
        if (pick < 15)
            return fresh_range();
        v = int'(prev) + ($urandom_range(1) ? int'($urandom_range(40)) : -int'($urandom_range(40)));
        if (v < 0)
            v = 0;
        if (v > int'(RANGE_TOP))
            v = int'(RANGE_TOP);
        return range_t'(v);
    endfunction

    // Queue whole scans; the last one always closes with its end mark
    task automatic queue_scans(int n_items);
        int     queued_n;
        int     scan_len;
        range_t cur;
        queued_n = 0;
        while (queued_n < n_items)
        begin
            scan_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
            if (scan_len > n_items - queued_n)
                scan_len = n_items - queued_n;
            cur = fresh_range();
            for (int k = 0; k < scan_len; k++)
            begin
                send(cur, k == scan_len - 1);
                cur = next_range(cur);
            end
            queued_n += scan_len;
        end
    endtask

    // Plausible sensor settings: small angular step, moderate thresholds
    task automatic load_realistic();
        write_reg(REG_RANGE_FLOOR, $urandom_range(8191));
        write_reg(REG_INVALID_VALUE, $urandom_range(RANGE_TOP));
        write_reg(REG_COS_INCREMENT, COS_UNITY - $urandom_range(20));
        write_reg(REG_SHADOW_SLOPE, $urandom_range(2000, 20));
        write_reg(REG_DIST_ALPHA, $urandom());
        if ($urandom_range(1))
            write_reg(REG_DIST_BETA, -int'($urandom_range(8388608)));
        else
            write_reg(REG_DIST_BETA, $urandom_range(SLOPE_TOP));
        settings_loaded++;
    endtask

    // Each register at one of its limits; beta may also be zero and the cosine unity
    task automatic load_extremes();
        int unsigned pick;
        write_reg(REG_RANGE_FLOOR, $urandom_range(1) ? RANGE_TOP : 32'd0);
        write_reg(REG_INVALID_VALUE, $urandom_range(1) ? RANGE_TOP : 32'd0);
        pick = $urandom_range(2);
        write_reg(REG_COS_INCREMENT, (pick == 0) ? 32'd0 : (pick == 1) ? COS_UNITY : COS_TOP);
        write_reg(REG_SHADOW_SLOPE, $urandom_range(1) ? SLOPE_TOP : 32'd0);
        write_reg(REG_DIST_ALPHA, $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0);
        pick = $urandom_range(2);
        write_reg(REG_DIST_BETA, (pick == 0) ? BETA_LEAST : (pick == 1) ? BETA_MOST : 32'd0);
        settings_loaded++;
    endtask

    // Full 32-bit data to every index, spare ones included
    task automatic load_raw();
        write_reg(SPARE_INDEX_A, $urandom());
        write_reg(REG_RANGE_FLOOR, $urandom());
        write_reg(REG_INVALID_VALUE, $urandom());
        write_reg(REG_COS_INCREMENT, $urandom());
        write_reg(REG_SHADOW_SLOPE, $urandom());
        write_reg(REG_DIST_ALPHA, $urandom());
        write_reg(REG_DIST_BETA, $urandom());
        write_reg(SPARE_INDEX_B, $urandom());
        settings_loaded++;
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: single-sample scans at both limits, a flat triple, a step
        set_pacing(0, 0);
        settings_loaded++;
        send('0, 1'b1);
        send(RANGE_SAT, 1'b1);
        send(range_t'(5000), 1'b0);
        send(range_t'(5000), 1'b0);
        send(range_t'(5000), 1'b1);
        send(range_t'(5000), 1'b0);
        send(range_t'(5001), 1'b1);
        wait_idle();

        // Denominator below, at and just above zero; sample at and under the minimum
        write_reg(REG_RANGE_FLOOR, 32'd500);
        write_reg(REG_INVALID_VALUE, 32'h0000_ABCD);
        write_reg(REG_SHADOW_SLOPE, SLOPE_TOP);
        write_reg(REG_DIST_ALPHA, 32'hFFFF_FFFF);
        write_reg(REG_DIST_BETA, -32'd1000000);
        settings_loaded++;
        send(range_t'(500), 1'b1);
        send(range_t'(499), 1'b1);
        send(range_t'(999), 1'b1);
        send(range_t'(1000), 1'b1);
        send(range_t'(1001), 1'b1);
        send(RANGE_SAT, 1'b1);
        wait_idle();

        // Largest positive beta, with and without a numerator
        write_reg(REG_DIST_BETA, BETA_MOST);
        write_reg(REG_DIST_ALPHA, 32'd0);
        settings_loaded++;
        send(range_t'(1001), 1'b1);
        wait_idle();
        write_reg(REG_DIST_ALPHA, 32'hFFFF_FFFF);
        settings_loaded++;
        send(range_t'(4096), 1'b1);
        wait_idle();

        // Invalid value under the minimum, zero cosine
        write_reg(REG_RANGE_FLOOR, RANGE_TOP);
        write_reg(REG_INVALID_VALUE, 32'd0);
        write_reg(REG_COS_INCREMENT, 32'd0);
        write_reg(REG_SHADOW_SLOPE, 32'd0);
        settings_loaded++;
        send('0, 1'b0);
        send(RANGE_SAT, 1'b1);
        wait_idle();

        // Cosine above one from an over-wide write; spare indices must be dropped
        write_reg(REG_RANGE_FLOOR, 32'd0);
        write_reg(REG_INVALID_VALUE, RANGE_TOP);
        write_reg(REG_COS_INCREMENT, 32'hFFFF_FFFF);
        write_reg(REG_DIST_ALPHA, 32'd0);
        write_reg(REG_DIST_BETA, BETA_LEAST);
        write_reg(SPARE_INDEX_A, $urandom());
        write_reg(SPARE_INDEX_B, $urandom());
        settings_loaded++;
        send(range_t'(4096), 1'b0);
        send(range_t'(8192), 1'b1);
        wait_idle();

        // Random scans under plausible settings, one pacing per phase
        load_realistic();
        set_pacing(0, 0);
        queue_scans(250);
        wait_idle();

        load_realistic();
        set_pacing(79, 0);
        queue_scans(250);
        wait_idle();

        load_realistic();
        set_pacing(0, 79);
        queue_scans(250);
        wait_idle();

        load_realistic();
        set_pacing(6, 6);
        queue_scans(250);
        wait_idle();

        // Register limits and raw writes, cycling through the pacings
        for (int p = 0; p < 8; p++)
        begin
            if (p < 4)
                load_extremes();
            else
                load_raw();
            unique case (p % 4)
                0: set_pacing(0, 0);
                1: set_pacing(79, 0);
                2: set_pacing(0, 79);
                default: set_pacing(6, 6);
            endcase
            queue_scans(60);
            wait_idle();
        end

        $display("Run covered %0d sample transactions and %0d checked results under %0d settings,",
                 samples_sent, results_checked, settings_loaded);
        $display("with register limits, spare indices, sender gaps and receiver stalls.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Abandon a hung run
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("Timeout with %0d results outstanding", expected_samples.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
